// ===== sv/stst_pkg.sv =====
// Shared types, constants and action codes for the typed slot table.
package stst_pkg;

  localparam int SLOT_W = 6;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int WORD_W = 32;
  localparam int ACT_W  = 4;

  localparam int TOTAL_SLOTS_DEF = 40;
  localparam int FONT_FIRST_DEF  = 0;
  localparam int FONT_END_DEF    = 8;
  localparam int IMAGE_FIRST_DEF = 8;
  localparam int IMAGE_END_DEF   = 40;

  localparam logic [WORD_W-1:0] ALIGN_MASK = 32'd3;
  localparam logic [WORD_W-1:0] LIMIT_RST  = 32'd1048576;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 4'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 4'd1;
  localparam logic [ACT_W-1:0] ACT_FIND   = 4'd2;
  localparam logic [ACT_W-1:0] ACT_COMMIT = 4'd3;
  localparam logic [ACT_W-1:0] ACT_BUMP   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_SETKEY = 4'd5;
  localparam logic [ACT_W-1:0] ACT_SETADR = 4'd6;
  localparam logic [ACT_W-1:0] ACT_SETMRK = 4'd7;
  localparam logic [ACT_W-1:0] ACT_READ   = 4'd8;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic KIND_IMAGE = 1'b0;

  typedef struct packed {
    logic              loaded;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } mem_cmd_t;

endpackage

// ===== sv/stst_mem.sv =====
// Entry memory with per-entry valid bits; invalid entries read as zero.
module stst_mem import stst_pkg::*; #(
  parameter int TOTAL_SLOTS = TOTAL_SLOTS_DEF,
  parameter int IDX_W       = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  mem_cmd_t         cmd,
  input  logic [IDX_W-1:0] wr_index,
  input  entry_t           wr_entry,
  input  logic [IDX_W-1:0] rd_index,
  output entry_t           rd_entry
);

  entry_t                 mem [TOTAL_SLOTS];
  logic [TOTAL_SLOTS-1:0] valid;
  entry_t                 rd_q;
  logic                   rd_vld;
  logic                   rd_in_range;

  // scan prefetch can step one past the last entry
  assign rd_in_range = {1'b0, rd_index} < (IDX_W+1)'(TOTAL_SLOTS);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_index] <= wr_entry;
    end
    if (rd_in_range) begin
      rd_q <= mem[rd_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.wr) begin
        valid[wr_index] <= 1'b1;
      end
      rd_vld <= rd_in_range && valid[rd_index];
    end
  end

  assign rd_entry = rd_vld ? rd_q : '0;

endmodule

// ===== sv/stst_ptr.sv =====
// Allocation pointer, limit register and overflow compare.
module stst_ptr import stst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic              advance,
  input  logic [WORD_W-1:0] size_bytes,
  output logic [WORD_W-1:0] ptr,
  output logic              over
);

  logic [WORD_W-1:0] limit;
  logic [WORD_W-1:0] ptr_next;

  assign ptr_next = (ptr + size_bytes + ALIGN_MASK) & ~ALIGN_MASK;
  assign over     = ptr > limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      limit <= LIMIT_RST;
    end else if (cfg_write) begin
      if (cfg_index == CFG_BASE) begin
        ptr <= cfg_data;
      end
      if (cfg_index == CFG_LIMIT) begin
        limit <= cfg_data;
      end
    end else if (advance) begin
      ptr <= ptr_next;
    end
  end

endmodule

// ===== sv/typed_slot_table_bump_allocator_unit.sv =====
// Top level: request sequencer around the entry memory and the pointer unit.
//
// A request is taken when start is high and busy is low; busy stays high
// until the result is produced. Each request yields one result, shown for a
// single cycle with done high; results cannot be held off.
// Steps from the accepting edge to the cycle with done high:
//   clear, unused actions, out-of-range slots: the finishing step only
//   commit, bump: pointer add, then limit compare
//   set key/address/mark: memory read, then write-back; read: memory read, then address capture
//   allocate, find: a scan over the slots examined (at most the range size), then the finishing step
// The scan reads one entry per cycle through the single memory read port,
// which sets the allocate/find time. A new request is accepted in the cycle
// done is high. Configuration writes (cfg_write, cfg_index, cfg_data) go in
// while idle; writing the base (CFG_BASE) loads the allocation pointer.
// Reset clears all entries at once through valid bits, loads the pointer
// with 0 and the limit with 1048576; the table is usable the next cycle.
module typed_slot_table_bump_allocator_unit import stst_pkg::*; #(
  parameter int TOTAL_SLOTS = TOTAL_SLOTS_DEF,
  parameter int FONT_FIRST  = FONT_FIRST_DEF,
  parameter int FONT_END    = FONT_END_DEF,
  parameter int IMAGE_FIRST = IMAGE_FIRST_DEF,
  parameter int IMAGE_END   = IMAGE_END_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic [ACT_W-1:0]  action,
  input  logic              kind,
  input  logic [SLOT_W-1:0] slot,
  input  logic [WORD_W-1:0] key,
  input  logic [WORD_W-1:0] address,
  input  logic [WORD_W-1:0] size_bytes,
  input  logic              mark,
  output logic              done,
  output logic [SLOT_W-1:0] slot_index,
  output logic              found,
  output logic [WORD_W-1:0] entry_address,
  output logic              overflow,
  output logic [WORD_W-1:0] next_free
);

  localparam int IDX_W    = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int FONT_HI  = (FONT_END > TOTAL_SLOTS) ? TOTAL_SLOTS : FONT_END;
  localparam int IMAGE_HI = (IMAGE_END > TOTAL_SLOTS) ? TOTAL_SLOTS : IMAGE_END;
  localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(TOTAL_SLOTS);
  localparam logic [CNT_W-1:0] FONT_LO  = CNT_W'(FONT_FIRST);
  localparam logic [CNT_W-1:0] FONT_HC  = CNT_W'(FONT_HI);
  localparam logic [CNT_W-1:0] IMAGE_LO = CNT_W'(IMAGE_FIRST);
  localparam logic [CNT_W-1:0] IMAGE_HC = CNT_W'(IMAGE_HI);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_ADV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state;
  logic [ACT_W-1:0]  req_act;
  logic [SLOT_W-1:0] req_slot;
  logic [WORD_W-1:0] req_key;
  logic [WORD_W-1:0] req_addr;
  logic [WORD_W-1:0] req_size;
  logic              req_mark;
  logic              req_adv;
  logic [CNT_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  scan_hi;
  logic [CNT_W-1:0]  chk_idx;
  logic              chk_live;
  logic [SLOT_W-1:0] res_slot;
  logic              res_found;
  logic [WORD_W-1:0] res_addr;

  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic              ok;
  logic              match;
  logic              chk_last;
  mem_cmd_t          cmd;
  logic [IDX_W-1:0]  wr_index;
  entry_t            wr_entry;
  logic [IDX_W-1:0]  rd_index;
  entry_t            rd_entry;
  logic              advance;
  logic [WORD_W-1:0] ptr;
  logic              over;

  assign busy     = state != S_IDLE;
  assign lo       = (kind == KIND_IMAGE) ? IMAGE_LO : FONT_LO;
  assign hi       = (kind == KIND_IMAGE) ? IMAGE_HC : FONT_HC;
  assign ok       = {1'b0, slot} < SLOTS_C;
  assign match    = chk_live && ((req_act == ACT_ALLOC) ? !rd_entry.loaded
                                                        : rd_entry.key == req_key);
  assign chk_last = chk_live && (chk_idx == scan_hi - CNT_W'(1));

  always_comb begin
    cmd      = '0;
    wr_index = req_slot[IDX_W-1:0];
    wr_entry = rd_entry;
    rd_index = scan_idx[IDX_W-1:0];
    advance  = 1'b0;
    case (state)
      S_RD: begin
        rd_index = req_slot[IDX_W-1:0];
      end
      S_MOD: begin
        case (req_act)
          ACT_SETKEY: begin
            cmd.wr       = 1'b1;
            wr_entry.key = req_key;
          end
          ACT_SETADR: begin
            cmd.wr        = 1'b1;
            wr_entry.addr = req_addr;
          end
          ACT_SETMRK: begin
            cmd.wr          = 1'b1;
            wr_entry.loaded = req_mark;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        wr_index = chk_idx[IDX_W-1:0];
        if (match && req_act == ACT_ALLOC) begin
          cmd.wr          = 1'b1;
          wr_entry.loaded = 1'b1;
        end
      end
      S_ADV: begin
        advance = 1'b1;
        if (req_act == ACT_COMMIT) begin
          cmd.wr   = 1'b1;
          wr_entry = '{loaded: 1'b1, key: req_key, addr: req_addr};
        end
      end
      S_FIN: begin
        cmd.clr = req_act == ACT_CLEAR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_act   <= action;
            req_slot  <= slot;
            req_key   <= key;
            req_addr  <= address;
            req_size  <= size_bytes;
            req_mark  <= mark;
            req_adv   <= (action == ACT_BUMP) || (action == ACT_COMMIT && ok);
            scan_idx  <= lo;
            scan_hi   <= hi;
            chk_live  <= 1'b0;
            res_slot  <= '0;
            res_found <= 1'b0;
            res_addr  <= '0;
            case (action)
              ACT_ALLOC, ACT_FIND: state <= (lo < hi) ? S_SCAN : S_FIN;
              ACT_COMMIT:          state <= ok ? S_ADV : S_FIN;
              ACT_BUMP:            state <= S_ADV;
              ACT_SETKEY, ACT_SETADR, ACT_SETMRK, ACT_READ:
                                   state <= ok ? S_RD : S_FIN;
              default:             state <= S_FIN;
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            res_slot  <= chk_idx[SLOT_W-1:0];
            res_found <= 1'b1;
            state     <= S_FIN;
          end else if (chk_last) begin
            state <= S_FIN;
          end else begin
            chk_idx  <= scan_idx;
            chk_live <= 1'b1;
            scan_idx <= scan_idx + CNT_W'(1);
          end
        end
        S_RD: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (req_act == ACT_READ) begin
            res_addr <= rd_entry.addr;
          end
          state <= S_FIN;
        end
        S_ADV: begin
          state <= S_FIN;
        end
        S_FIN: begin
          done          <= 1'b1;
          slot_index    <= res_slot;
          found         <= res_found;
          entry_address <= res_addr;
          overflow      <= req_adv && over;
          next_free     <= ptr;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  stst_mem #(
    .TOTAL_SLOTS (TOTAL_SLOTS),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .wr_index (wr_index),
    .wr_entry (wr_entry),
    .rd_index (rd_index),
    .rd_entry (rd_entry)
  );

  stst_ptr u_ptr (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (advance),
    .size_bytes (req_size),
    .ptr        (ptr),
    .over       (over)
  );

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIN))
    else $error("result strobe without a finishing step");

  a_found_in_table: assert property (@(posedge clk) disable iff (rst)
    done && found |-> {1'b0, slot_index} < SLOTS_C)
    else $error("reported slot beyond table");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && chk_live |-> chk_idx < scan_hi)
    else $error("scan checked a slot past the range end");

  a_ovf_only_adv: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> $past(req_adv))
    else $error("overflow on a request that does not move the pointer");

  a_ptr_steady: assert property (@(posedge clk) disable iff (rst)
    busy && state != S_ADV && !cfg_write |=> $stable(ptr))
    else $error("pointer moved outside an advance step");

endmodule
